### rtl/crc32_frame_receiver_unit_assert.svh
// Assertion macros for the CRC-32 frame receiver.
// No dependencies; the assertions compile away when SYNTHESIS is defined.
`ifndef CRC32_FRAME_RECEIVER_UNIT_ASSERT_SVH
`define CRC32_FRAME_RECEIVER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside of reset
`define CRC32FR_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("crc32fr assertion failed");
// Check a property on every clock edge, reset included
`define CRC32FR_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("crc32fr assertion failed");
`else
`define CRC32FR_ASSERT(label, clk, rst_n, prop)
`define CRC32FR_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

### rtl/crc32fr_pkg.sv
// Shared types, codes and the byte-wide CRC-32 update for the frame receiver.
// No dependencies.
`timescale 1ns / 1ps

package crc32fr_pkg;

    // CRC-32, MSB first, no reflection, no final xor
    localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // Configuration register indexes
    localparam logic [1:0] CFG_IDX_START_BYTE = 2'd0;
    localparam logic [1:0] CFG_IDX_MAX_LENGTH = 2'd1;
    localparam logic [1:0] CFG_IDX_TIMEOUT    = 2'd2;

    // Configuration reset values
    localparam logic [7:0]  START_BYTE_RST    = 8'd170;
    localparam logic [15:0] MAX_LENGTH_RST    = 16'd256;
    localparam logic [19:0] TIMEOUT_TICKS_RST = 20'd300;

    // Input opcodes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Result kinds
    localparam logic KIND_PAYLOAD   = 1'b0;
    localparam logic KIND_FRAME_END = 1'b1;

    // Verdict codes
    localparam logic [1:0] VERDICT_OK      = 2'd0;
    localparam logic [1:0] VERDICT_CRC_ERR = 2'd1;
    localparam logic [1:0] VERDICT_TIMEOUT = 2'd2;

    typedef struct packed {
        logic [7:0]  start_byte;
        logic [15:0] max_length;
        logic [19:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [7:0]  command;
        logic [15:0] frame_length;
        logic [1:0]  verdict;
    } result_t;

    // One byte through the CRC register, eight shift steps
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] data);
        logic [31:0] c;
        c = crc ^ {data, 24'd0};
        for (int k = 0; k < 8; k++) begin
            if (c[31]) begin
                c = {c[30:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[30:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### rtl/crc32fr_cfg_regs.sv
// Configuration register file of the frame receiver.
// Depends on crc32fr_pkg.
`timescale 1ns / 1ps

module crc32fr_cfg_regs
    import crc32fr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Always able to take a write transaction
    assign cfg_ready = 1'b1;

    // Register decode; an index past the list is dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_IDX_START_BYTE: cfg_next.start_byte    = cfg_data[7:0];
                CFG_IDX_MAX_LENGTH: cfg_next.max_length    = cfg_data[15:0];
                CFG_IDX_TIMEOUT:    cfg_next.timeout_ticks = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_byte    <= START_BYTE_RST;
            cfg_reg.max_length    <= MAX_LENGTH_RST;
            cfg_reg.timeout_ticks <= TIMEOUT_TICKS_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/crc32fr_deframer.sv
// Frame parsing state machine with running CRC-32 and timeout counter.
// Depends on crc32fr_pkg and crc32_frame_receiver_unit_assert.svh.
`timescale 1ns / 1ps
`include "crc32_frame_receiver_unit_assert.svh"

module crc32fr_deframer
    import crc32fr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic       opcode,
    input  logic [7:0] rx_byte,
    input  cfg_t       cfg,
    output logic       res_valid,
    output result_t    res
);

    typedef enum logic [8:0] {
        ST_HUNT = 9'b0_0000_0001,
        ST_CMD  = 9'b0_0000_0010,
        ST_LEN1 = 9'b0_0000_0100,
        ST_LEN2 = 9'b0_0000_1000,
        ST_DATA = 9'b0_0001_0000,
        ST_CRC1 = 9'b0_0010_0000,
        ST_CRC2 = 9'b0_0100_0000,
        ST_CRC3 = 9'b0_1000_0000,
        ST_CRC4 = 9'b1_0000_0000
    } state_t;

    state_t      state_reg, state_next;
    logic [7:0]  command_reg, command_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] byte_index_reg, byte_index_next;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] rx_crc_reg, rx_crc_next;
    logic [19:0] idle_reg, idle_next;

    logic [31:0] crc_fed;
    logic [19:0] idle_inc;
    logic [15:0] len_full;
    logic [15:0] index_inc;
    logic [31:0] rx_crc_full;

    assign crc_fed     = crc32_byte(crc_reg, rx_byte);
    assign idle_inc    = idle_reg + 20'd1;
    assign len_full    = {rx_byte, length_reg[7:0]};
    assign index_inc   = byte_index_reg + 16'd1;
    assign rx_crc_full = {rx_byte, rx_crc_reg[23:0]};

    // Next state and result for the item in the input register
    always_comb begin
        state_next      = state_reg;
        command_next    = command_reg;
        length_next     = length_reg;
        byte_index_next = byte_index_reg;
        crc_next        = crc_reg;
        rx_crc_next     = rx_crc_reg;
        idle_next       = idle_reg;
        res_valid       = 1'b0;
        res.kind         = KIND_PAYLOAD;
        res.payload_byte = 8'd0;
        res.command      = command_reg;
        res.frame_length = length_reg;
        res.verdict      = VERDICT_OK;

        if (opcode == OP_TICK) begin
            if (state_reg == ST_HUNT) begin
                idle_next = 20'd0;
            end else if (idle_inc >= cfg.timeout_ticks) begin
                // Link went quiet mid-frame: abort
                state_next  = ST_HUNT;
                idle_next   = 20'd0;
                res_valid   = 1'b1;
                res.kind    = KIND_FRAME_END;
                res.verdict = VERDICT_TIMEOUT;
            end else begin
                idle_next = idle_inc;
            end
        end else begin
            idle_next = 20'd0;
            unique case (state_reg)
                ST_CMD: begin
                    command_next = rx_byte;
                    crc_next     = crc_fed;
                    state_next   = ST_LEN1;
                end
                ST_LEN1: begin
                    length_next = {8'd0, rx_byte};
                    crc_next    = crc_fed;
                    state_next  = ST_LEN2;
                end
                ST_LEN2: begin
                    length_next = len_full;
                    crc_next    = crc_fed;
                    if (len_full >= cfg.max_length) begin
                        state_next = ST_HUNT;
                    end else if (len_full == 16'd0) begin
                        state_next = ST_CRC1;
                    end else begin
                        state_next = ST_DATA;
                    end
                end
                ST_DATA: begin
                    crc_next        = crc_fed;
                    byte_index_next = index_inc;
                    if (index_inc >= length_reg) begin
                        state_next = ST_CRC1;
                    end
                    res_valid        = 1'b1;
                    res.payload_byte = rx_byte;
                end
                ST_CRC1: begin
                    rx_crc_next = {24'd0, rx_byte};
                    state_next  = ST_CRC2;
                end
                ST_CRC2: begin
                    rx_crc_next = {16'd0, rx_byte, rx_crc_reg[7:0]};
                    state_next  = ST_CRC3;
                end
                ST_CRC3: begin
                    rx_crc_next = {8'd0, rx_byte, rx_crc_reg[15:0]};
                    state_next  = ST_CRC4;
                end
                ST_CRC4: begin
                    rx_crc_next = rx_crc_full;
                    state_next  = ST_HUNT;
                    res_valid   = 1'b1;
                    res.kind    = KIND_FRAME_END;
                    res.verdict = (rx_crc_full == crc_reg) ? VERDICT_OK : VERDICT_CRC_ERR;
                end
                default: begin
                    // Hunting for the start marker
                    state_next = ST_HUNT;
                    if (rx_byte == cfg.start_byte) begin
                        state_next      = ST_CMD;
                        byte_index_next = 16'd0;
                        length_next     = 16'd0;
                        rx_crc_next     = 32'd0;
                        crc_next        = CRC_INIT;
                    end
                end
            endcase
        end
    end

    // Frame state registers, updated once per processed item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_HUNT;
            command_reg    <= 8'd0;
            length_reg     <= 16'd0;
            byte_index_reg <= 16'd0;
            crc_reg        <= CRC_INIT;
            rx_crc_reg     <= 32'd0;
            idle_reg       <= 20'd0;
        end else if (step) begin
            state_reg      <= state_next;
            command_reg    <= command_next;
            length_reg     <= length_next;
            byte_index_reg <= byte_index_next;
            crc_reg        <= crc_next;
            rx_crc_reg     <= rx_crc_next;
            idle_reg       <= idle_next;
        end
    end

    // In the payload the byte counter stays below the declared length
    `CRC32FR_ASSERT(a_data_index, aclk, aresetn,
        (state_reg == ST_DATA) |-> (length_reg != 16'd0 && byte_index_reg < length_reg))
    // The idle counter only runs mid-frame
    `CRC32FR_ASSERT(a_hunt_idle, aclk, aresetn, (state_reg == ST_HUNT) |-> (idle_reg == 20'd0))
    // State only moves on a processed item
    `CRC32FR_ASSERT(a_hold_state, aclk, aresetn,
        !step |=> $stable(state_reg) && $stable(crc_reg))

endmodule

### rtl/crc32_frame_receiver_unit.sv
// Top level of the CRC-32 frame receiver: input register, deframer, result register.
// Depends on crc32fr_pkg, crc32fr_cfg_regs, crc32fr_deframer and the assertion header.
//
// Usage:
//   Input channel (s_valid/s_ready, s_opcode, s_rx_byte): one transaction per received
//   byte (opcode 0) or per timer tick (opcode 1).
//   Result channel (m_valid/m_ready, m_kind ...): one transaction per payload byte and
//   one closing transaction per frame with command, length and verdict (ok, CRC
//   mismatch, timeout). Frames with a length at or above the maximum are dropped without a result.
//   Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 start byte,
//   1 maximum length, 2 timeout in ticks. cfg_ready is always high; write only while idle.
// Timing:
//   An accepted transaction is registered, then stepped through the deframer and the CRC
//   unit into the result register if it yields a result; throughput one transaction per
//   cycle while the result register is not held by a low m_ready.
// Reset (aresetn low, synchronous): hunting state, CRC all ones, both registers empty,
//   configuration back to its defaults.
// Stall: when m_ready is low the result is held; one more transaction waits in the input
//   register, after which s_ready drops until the result is taken.
`timescale 1ns / 1ps
`include "crc32_frame_receiver_unit_assert.svh"

module crc32_frame_receiver_unit
    import crc32fr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_opcode,
    input  logic [7:0]  s_rx_byte,
    // Result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [7:0]  m_payload_byte,
    output logic [7:0]  m_command,
    output logic [15:0] m_frame_length,
    output logic [1:0]  m_verdict,
    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_data
);

    logic       in_valid_reg, in_valid_next;
    logic       in_opcode_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg, out_valid_next;
    result_t    out_reg;

    logic       step;
    logic       s_take;
    logic       res_valid;
    result_t    res;
    cfg_t       cfg;

    // Handshake: the held item steps when the result register is free or draining
    assign step    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step;
    assign s_take  = s_valid && s_ready;

    crc32fr_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    crc32fr_deframer u_deframer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .opcode    (in_opcode_reg),
        .rx_byte   (in_byte_reg),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Valid flags of the two registers
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (step) begin
            out_valid_next = res_valid;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_opcode_reg <= s_opcode;
            in_byte_reg   <= s_rx_byte;
        end
        if (step && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_kind         = out_reg.kind;
    assign m_payload_byte = out_reg.payload_byte;
    assign m_command      = out_reg.command;
    assign m_frame_length = out_reg.frame_length;
    assign m_verdict      = out_reg.verdict;

    // Both registers come up empty
    `CRC32FR_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid && s_ready)
    // Backpressure only with an item parked in the input register
    `CRC32FR_ASSERT(a_ready_stall, aclk, aresetn,
        !s_ready |-> in_valid_reg && out_valid_reg && !m_ready)
    // Payload results carry no verdict
    `CRC32FR_ASSERT(a_payload_verdict, aclk, aresetn,
        (m_valid && m_kind == KIND_PAYLOAD) |-> (m_verdict == VERDICT_OK))

endmodule
